// File: hdl/dsf_pkg.sv
// ----------------------------------------------------------------------------
// dsf_pkg: shared types and constants for the damped 2-D spring block
// Fixed field widths, register codes and side-band records carried through
// the long arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package dsf_pkg;

	localparam int POS_W    = 32;  // position and velocity fields
	localparam int DIFF_W   = 33;  // end-to-end differences
	localparam int SQ_W     = 65;  // sum of squares
	localparam int LEN_W    = 33;  // internal length
	localparam int DIR_BITS = 30;  // fraction bits of the unit direction
	localparam int UNIT_W   = 32;  // direction component, signed
	localparam int EXT_W    = 35;  // extension and closing speed, signed
	localparam int CFG_W    = 31;  // register width
	localparam int IDX_W    = 2;   // register index width
	localparam int OUT_W    = 31;  // unsigned result fields

	typedef enum logic [IDX_W-1:0] {
		REG_REST_LENGTH = 2'd0,
		REG_STIFFNESS   = 2'd1,
		REG_DAMPING     = 2'd2
	} cfg_reg_t;

	// differences carried through the squaring and the root
	typedef struct packed {
		logic signed [DIFF_W-1:0] rvx;
		logic signed [DIFF_W-1:0] rvy;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} geom_t;

	// carried through the direction dividers
	typedef struct packed {
		logic signed [DIFF_W-1:0] rvx;
		logic signed [DIFF_W-1:0] rvy;
		logic [LEN_W-1:0]         len;
		logic                     neg_x;
		logic                     neg_y;
	} dir_side_t;

	// carried through the speed multipliers
	typedef struct packed {
		logic signed [UNIT_W-1:0] ux;
		logic signed [UNIT_W-1:0] uy;
		logic signed [EXT_W-1:0]  ext;
		logic [LEN_W-1:0]         len;
	} unit_side_t;

endpackage

`default_nettype wire

// File: hdl/dsf_mul.sv
// ----------------------------------------------------------------------------
// dsf_mul: two-stage signed multiplier lanes
// B is cut into 17-bit slices; slice products are registered, then summed.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_mul #(
	parameter int N   = 2,
	parameter int AW  = 32,
	parameter int BW  = 32,
	parameter int SDW = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vin,
	input  wire logic [N-1:0][AW-1:0]       a,
	input  wire logic [N-1:0][BW-1:0]       b,
	input  wire logic [SDW-1:0]             side_in,
	output logic                            vout,
	output logic [N-1:0][AW+BW-1:0]         p,
	output logic [SDW-1:0]                  side_out
);

	localparam int CW  = 17;
	localparam int NC  = (BW + CW - 1) / CW;
	localparam int TW  = BW - (NC - 1) * CW;
	localparam int PPW = AW + CW + 1;
	localparam int PW  = AW + BW;

	logic signed [PPW-1:0] pp_c  [N][NC];
	logic signed [PPW-1:0] pp_s1 [N][NC];
	logic [SDW-1:0]        side_s1;
	logic                  v_s1;
	logic [N-1:0][PW-1:0]  p_c;

	// slice products: lower slices unsigned, top slice signed
	always_comb begin
		logic signed [CW:0] chunk;
		for (int n = 0; n < N; n++) begin
			for (int c = 0; c < NC; c++) begin
				if (c < NC - 1) begin
					chunk = {1'b0, b[n][c*CW +: CW]};
				end else begin
					chunk = (CW+1)'($signed(b[n][BW-1 -: TW]));
				end
				pp_c[n][c] = PPW'($signed(a[n]) * chunk);
			end
		end
	end

	always_comb begin
		logic signed [PW-1:0] acc;
		for (int n = 0; n < N; n++) begin
			acc = '0;
			for (int c = 0; c < NC; c++) begin
				acc = acc + (PW'(pp_s1[n][c]) <<< (c * CW));
			end
			p_c[n] = acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			vout <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1    <= pp_c;
			side_s1  <= side_in;
			p        <= p_c;
			side_out <= side_s1;
		end
	end

endmodule

`default_nettype wire

// File: hdl/dsf_sqrt.sv
// ----------------------------------------------------------------------------
// dsf_sqrt: pipelined integer square root
// One digit pair per stage, LEN_W stages, floor root of a SQ_W-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_sqrt #(
	parameter int SDW = 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      vin,
	input  wire logic [dsf_pkg::SQ_W-1:0]  x,
	input  wire logic [SDW-1:0]            side_in,
	output logic                           vout,
	output logic [dsf_pkg::LEN_W-1:0]      root,
	output logic [SDW-1:0]                 side_out
);

	localparam int STEPS = dsf_pkg::LEN_W;
	localparam int XW    = dsf_pkg::SQ_W + 1;
	localparam int RW    = dsf_pkg::LEN_W + 2;

	logic [XW-1:0]     x_s    [STEPS];
	logic [STEPS-1:0]  root_s [STEPS];
	logic [RW-1:0]     rem_s  [STEPS];
	logic [SDW-1:0]    side_s [STEPS];
	logic              v_s    [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam int K = STEPS - 1 - i;
		logic [XW-1:0]    xi;
		logic [STEPS-1:0] ri;
		logic [RW-1:0]    mi;
		logic [SDW-1:0]   si;
		logic             vi;
		logic [RW+1:0]    acc;
		logic [RW+1:0]    trial;

		if (i == 0) begin : g_first
			assign xi = {1'b0, x};
			assign ri = '0;
			assign mi = '0;
			assign si = side_in;
			assign vi = vin;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign ri = root_s[i-1];
			assign mi = rem_s[i-1];
			assign si = side_s[i-1];
			assign vi = v_s[i-1];
		end

		assign acc   = {mi, xi[2*K+1 -: 2]};
		assign trial = (RW+2)'({ri, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]    <= xi;
				side_s[i] <= si;
				if (acc >= trial) begin
					rem_s[i]  <= RW'(acc - trial);
					root_s[i] <= {ri[STEPS-2:0], 1'b1};
				end else begin
					rem_s[i]  <= acc[RW-1:0];
					root_s[i] <= {ri[STEPS-2:0], 1'b0};
				end
			end
		end
	end

	assign vout     = v_s[STEPS-1];
	assign root     = root_s[STEPS-1];
	assign side_out = side_s[STEPS-1];

endmodule

`default_nettype wire

// File: hdl/dsf_div.sv
// ----------------------------------------------------------------------------
// dsf_div: pipelined restoring divider for the unit direction
// quo = (num << DIR_BITS) / den for N lanes sharing one divisor; needs
// num <= den, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_div #(
	parameter int N   = 2,
	parameter int NW  = 32,
	parameter int SDW = 1
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   vin,
	input  wire logic [N-1:0][NW-1:0]                   num,
	input  wire logic [dsf_pkg::LEN_W-1:0]              den,
	input  wire logic [SDW-1:0]                         side_in,
	output logic                                        vout,
	output logic [N-1:0][dsf_pkg::DIR_BITS:0]           quo,
	output logic [SDW-1:0]                              side_out
);

	localparam int DW = dsf_pkg::LEN_W;
	localparam int QW = dsf_pkg::DIR_BITS + 1;

	logic [N-1:0][DW-1:0] rem_s  [QW];
	logic [N-1:0][QW-1:0] quo_s  [QW];
	logic [DW-1:0]        den_s  [QW];
	logic [SDW-1:0]       side_s [QW];
	logic                 v_s    [QW];

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [N-1:0][DW-1:0] ri;
		logic [N-1:0][QW-1:0] qi;
		logic [DW-1:0]        di;
		logic [SDW-1:0]       si;
		logic                 vi;
		logic [N-1:0][DW-1:0] ro;
		logic [N-1:0][QW-1:0] qo;

		if (j == 0) begin : g_first
			assign ri = '0;
			assign qi = '0;
			assign di = den;
			assign si = side_in;
			assign vi = vin;
		end else begin : g_next
			assign ri = rem_s[j-1];
			assign qi = quo_s[j-1];
			assign di = den_s[j-1];
			assign si = side_s[j-1];
			assign vi = v_s[j-1];
		end

		// first step takes the whole numerator, later ones shift in zeros
		always_comb begin
			logic [DW:0] acc;
			for (int n = 0; n < N; n++) begin
				acc = (j == 0) ? (DW+1)'(num[n]) : {ri[n], 1'b0};
				if (acc >= {1'b0, di}) begin
					ro[n] = DW'(acc - {1'b0, di});
					qo[n] = {qi[n][QW-2:0], 1'b1};
				end else begin
					ro[n] = acc[DW-1:0];
					qo[n] = {qi[n][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ro;
				quo_s[j]  <= qo;
				den_s[j]  <= di;
				side_s[j] <= si;
			end
		end
	end

	assign vout     = v_s[QW-1];
	assign quo      = quo_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

`default_nettype wire

// File: hdl/damped_spring_force_2d.sv
// ----------------------------------------------------------------------------
// damped_spring_force_2d: damped spring force, length and energy in 2-D
// Fully pipelined: one spring word per clock through root, divide and MACs while the output word is not held.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one spring word per beat: positions and
//   velocities of both ends. Output stream m_axis returns force on end A
//   (end B takes the negation), the length and the stored energy.
//   Registers rest_length, stiffness and damping are written through the
//   cfg port; the user must write them only while the block is idle, and
//   the block itself does not enforce it. Words in flight may see a new value.
//   Each word passes the 33-stage square root and the 31-stage direction divider.
//   Throughput: one word per clock while the output word is not held.
//   Stall: the whole pipeline holds while the output word waits; the input
//   ready is low only then, so nothing is dropped or repeated.
//   Reset: all valid bits clear, rest_length returns to 1.0, stiffness and
//   damping to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module damped_spring_force_2d #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// end_a_x, end_a_y, end_b_x, end_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y
	input  wire logic [255:0]                s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// force_a_x, force_a_y, spring_length, potential_energy, 2 zero bits
	output logic [127:0]                     m_axis_tdata,
	input  wire logic                        cfg_we,
	input  wire logic [dsf_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [dsf_pkg::CFG_W-1:0]   cfg_data
);

	localparam int POS_W  = dsf_pkg::POS_W;
	localparam int DIFF_W = dsf_pkg::DIFF_W;
	localparam int LEN_W  = dsf_pkg::LEN_W;
	localparam int UNIT_W = dsf_pkg::UNIT_W;
	localparam int EXT_W  = dsf_pkg::EXT_W;
	localparam int CFG_W  = dsf_pkg::CFG_W;
	localparam int OUT_W  = dsf_pkg::OUT_W;
	localparam int DIRB   = dsf_pkg::DIR_BITS;
	localparam int SW     = 67 - FRAC_BITS;   // scalar and squared extension
	localparam int M0P    = 2 * DIFF_W;
	localparam int M1P    = 2 * EXT_W;
	localparam int M3P    = UNIT_W + SW;
	localparam int S2W    = 2 * UNIT_W + SW + LEN_W;

	// ---------------- registers ----------------
	logic [CFG_W-1:0] rest_length_q, stiffness_q, damping_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_length_q <= CFG_W'(1) << FRAC_BITS;
			stiffness_q   <= '0;
			damping_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dsf_pkg::REG_REST_LENGTH: rest_length_q <= cfg_data;
				dsf_pkg::REG_STIFFNESS:   stiffness_q   <= cfg_data;
				dsf_pkg::REG_DAMPING:     damping_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic signed [DIFF_W-1:0] diff(input logic [POS_W-1:0] hi,
	                                                   input logic [POS_W-1:0] lo);
		diff = $signed({hi[POS_W-1], hi}) - $signed({lo[POS_W-1], lo});
	endfunction

	function automatic logic [POS_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
		logic [DIFF_W-1:0] t;
		t = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
		mag = t[POS_W-1:0];
	endfunction

	// the whole pipe advances unless the output word is held
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- input fields ----------------
	logic [POS_W-1:0] end_a_x, end_a_y, end_b_x, end_b_y;
	logic [POS_W-1:0] vel_a_x, vel_a_y, vel_b_x, vel_b_y;
	assign end_a_x = s_axis_tdata[31:0];
	assign end_a_y = s_axis_tdata[63:32];
	assign end_b_x = s_axis_tdata[95:64];
	assign end_b_y = s_axis_tdata[127:96];
	assign vel_a_x = s_axis_tdata[159:128];
	assign vel_a_y = s_axis_tdata[191:160];
	assign vel_b_x = s_axis_tdata[223:192];
	assign vel_b_y = s_axis_tdata[255:224];

	// ---------------- stage 1: differences ----------------
	logic          v_s1;
	dsf_pkg::geom_t geom_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geom_s1.dx  <= diff(end_b_x, end_a_x);
			geom_s1.dy  <= diff(end_b_y, end_a_y);
			geom_s1.rvx <= diff(vel_b_x, vel_a_x);
			geom_s1.rvy <= diff(vel_b_y, vel_a_y);
		end
	end

	// ---------------- squares ----------------
	logic                   v_m0;
	logic [1:0][M0P-1:0]    sq_m0;
	dsf_pkg::geom_t         geom_m0;

	dsf_mul #(.N(2), .AW(DIFF_W), .BW(DIFF_W), .SDW($bits(dsf_pkg::geom_t))) u_mul_sq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_s1),
		.a        ({geom_s1.dy, geom_s1.dx}),
		.b        ({geom_s1.dy, geom_s1.dx}),
		.side_in  (geom_s1),
		.vout     (v_m0),
		.p        (sq_m0),
		.side_out (geom_m0)
	);

	// ---------------- stage 2: sum of squares ----------------
	logic                        v_s2;
	logic [dsf_pkg::SQ_W-1:0]    sum_s2;
	dsf_pkg::geom_t              geom_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_m0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= {1'b0, sq_m0[0][63:0]} + {1'b0, sq_m0[1][63:0]};
			geom_s2 <= geom_m0;
		end
	end

	// ---------------- length ----------------
	logic             v_rt;
	logic [LEN_W-1:0] len_rt;
	dsf_pkg::geom_t   geom_rt;

	dsf_sqrt #(.SDW($bits(dsf_pkg::geom_t))) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_s2),
		.x        (sum_s2),
		.side_in  (geom_s2),
		.vout     (v_rt),
		.root     (len_rt),
		.side_out (geom_rt)
	);

	// ---------------- direction ----------------
	dsf_pkg::dir_side_t     dir_in, dir_dv;
	logic                   v_dv;
	logic [1:0][DIRB:0]     quo_dv;

	always_comb begin
		dir_in.rvx   = geom_rt.rvx;
		dir_in.rvy   = geom_rt.rvy;
		dir_in.len   = len_rt;
		dir_in.neg_x = geom_rt.dx[DIFF_W-1];
		dir_in.neg_y = geom_rt.dy[DIFF_W-1];
	end

	dsf_div #(.N(2), .NW(POS_W), .SDW($bits(dsf_pkg::dir_side_t))) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_rt),
		.num      ({mag(geom_rt.dy), mag(geom_rt.dx)}),
		.den      (len_rt),
		.side_in  (dir_in),
		.vout     (v_dv),
		.quo      (quo_dv),
		.side_out (dir_dv)
	);

	// ---------------- stage 3: signed direction, extension ----------------
	logic                      v_s3;
	logic signed [UNIT_W-1:0]  ux_s3, uy_s3;
	logic signed [EXT_W-1:0]   ext_s3;
	logic [LEN_W-1:0]          len_s3;
	logic signed [DIFF_W-1:0]  rvx_s3, rvy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_dv;
		end
	end

	// zero length falls back to the direction (1, 0)
	always_ff @(posedge clk) begin
		if (en) begin
			if (dir_dv.len == '0) begin
				ux_s3 <= UNIT_W'(1) << DIRB;
				uy_s3 <= '0;
			end else begin
				ux_s3 <= dir_dv.neg_x ? -$signed({1'b0, quo_dv[0]}) : $signed({1'b0, quo_dv[0]});
				uy_s3 <= dir_dv.neg_y ? -$signed({1'b0, quo_dv[1]}) : $signed({1'b0, quo_dv[1]});
			end
			ext_s3 <= $signed({2'b0, dir_dv.len}) - $signed({4'b0, rest_length_q});
			len_s3 <= dir_dv.len;
			rvx_s3 <= dir_dv.rvx;
			rvy_s3 <= dir_dv.rvy;
		end
	end

	// ---------------- closing speed and squared extension ----------------
	dsf_pkg::unit_side_t   us_in, us_m1;
	logic                  v_m1;
	logic [2:0][M1P-1:0]   pr_m1;

	always_comb begin
		us_in.ux  = ux_s3;
		us_in.uy  = uy_s3;
		us_in.ext = ext_s3;
		us_in.len = len_s3;
	end

	dsf_mul #(.N(3), .AW(EXT_W), .BW(EXT_W), .SDW($bits(dsf_pkg::unit_side_t))) u_mul_spd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_s3),
		.a        ({ext_s3, EXT_W'(uy_s3), EXT_W'(ux_s3)}),
		.b        ({ext_s3, EXT_W'(rvy_s3), EXT_W'(rvx_s3)}),
		.side_in  (us_in),
		.vout     (v_m1),
		.p        (pr_m1),
		.side_out (us_m1)
	);

	// ---------------- stage 4: speed, squared extension ----------------
	logic                      v_s4;
	logic signed [EXT_W-1:0]   speed_s4, ext_s4;
	logic [SW-1:0]             ext2_s4;
	logic signed [UNIT_W-1:0]  ux_s4, uy_s4;
	logic [LEN_W-1:0]          len_s4;
	logic signed [M1P-1:0]     dot;

	assign dot = $signed(pr_m1[0]) + $signed(pr_m1[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			speed_s4 <= dot[DIRB +: EXT_W];
			ext2_s4  <= pr_m1[2][FRAC_BITS +: SW];
			ext_s4   <= us_m1.ext;
			ux_s4    <= us_m1.ux;
			uy_s4    <= us_m1.uy;
			len_s4   <= us_m1.len;
		end
	end

	// ---------------- spring and damper terms ----------------
	logic                  v_m2;
	logic [1:0][M1P-1:0]   pr_m2;
	logic [S2W-1:0]        side_m2;

	dsf_mul #(.N(2), .AW(EXT_W), .BW(EXT_W), .SDW(S2W)) u_mul_scl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_s4),
		.a        ({{4'b0, damping_q}, {4'b0, stiffness_q}}),
		.b        ({speed_s4, ext_s4}),
		.side_in  ({ux_s4, uy_s4, ext2_s4, len_s4}),
		.vout     (v_m2),
		.p        (pr_m2),
		.side_out (side_m2)
	);

	// ---------------- stage 5: force scalar ----------------
	logic                      v_s5;
	logic signed [SW-1:0]      scalar_s5;
	logic [SW-1:0]             ext2_s5;
	logic signed [UNIT_W-1:0]  ux_s5, uy_s5;
	logic [LEN_W-1:0]          len_s5;
	logic signed [M1P:0]       ssum;

	assign ssum = (M1P+1)'($signed(pr_m2[0])) + (M1P+1)'($signed(pr_m2[1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scalar_s5 <= ssum[FRAC_BITS +: SW];
			len_s5    <= side_m2[LEN_W-1:0];
			ext2_s5   <= side_m2[LEN_W +: SW];
			uy_s5     <= side_m2[LEN_W + SW +: UNIT_W];
			ux_s5     <= side_m2[LEN_W + SW + UNIT_W +: UNIT_W];
		end
	end

	// ---------------- force and energy products ----------------
	logic                  v_m3;
	logic [2:0][M3P-1:0]   pr_m3;
	logic [LEN_W-1:0]      len_m3;

	dsf_mul #(.N(3), .AW(UNIT_W), .BW(SW), .SDW(LEN_W)) u_mul_frc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_s5),
		.a        ({{1'b0, stiffness_q}, uy_s5, ux_s5}),
		.b        ({ext2_s5, scalar_s5, scalar_s5}),
		.side_in  (len_s5),
		.vout     (v_m3),
		.p        (pr_m3),
		.side_out (len_m3)
	);

	// ---------------- stage 6: saturate, output word ----------------
	function automatic logic [POS_W-1:0] sat_force(input logic [M3P-1:0] v);
		logic [M3P-1:DIRB+POS_W-1] hi;
		hi = v[M3P-1:DIRB+POS_W-1];
		if ((&hi) || !(|hi)) begin
			sat_force = v[DIRB +: POS_W];
		end else if (v[M3P-1]) begin
			sat_force = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			sat_force = {1'b0, {(POS_W-1){1'b1}}};
		end
	endfunction

	logic               v_s6;
	logic [POS_W-1:0]   force_x_s6, force_y_s6;
	logic [OUT_W-1:0]   length_s6, energy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_m3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			force_x_s6 <= sat_force(pr_m3[0]);
			force_y_s6 <= sat_force(pr_m3[1]);
			length_s6  <= (|len_m3[LEN_W-1:OUT_W]) ? {OUT_W{1'b1}} : len_m3[OUT_W-1:0];
			energy_s6  <= (|pr_m3[2][M3P-1:FRAC_BITS+1+OUT_W]) ? {OUT_W{1'b1}}
			                                                    : pr_m3[2][FRAC_BITS+1 +: OUT_W];
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {2'b00, energy_s6, length_s6, force_y_s6, force_x_s6};

endmodule

`default_nettype wire

// File: hdl/dsf_checker.sv
// ----------------------------------------------------------------------------
// dsf_checker: port-level checks for the damped spring block
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [127:0] m_axis_tdata
);

	// a held output word keeps its value
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// input back-pressure only while an output word is waiting
	a_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

	// zero length means direction (1,0), so no y force
	a_zero_len : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[94:64] == 31'd0 |-> m_axis_tdata[63:32] == 32'd0)
		else $error("y force on zero-length spring");

	// padding bits stay clear
	a_pad : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[127:126] == 2'b00)
		else $error("padding bits set");

endmodule

bind damped_spring_force_2d dsf_checker u_dsf_checker (.*);

`default_nettype wire
